### rtl/cpsd_pkg.sv
package cpsd_pkg;

	localparam int NUM_COORDS      = 8;
	localparam int MAX_POINTS_DEF  = 64;
	localparam int MAX_DIM_DEF     = 8;
	localparam int COORD_BITS_DEF  = 16;
	localparam int DIST_BITS       = 18;
	localparam int DIST_TDATA_BITS = 24;
	localparam int CMD_BITS        = 2;
	localparam int DIM_BITS        = 4;

	localparam logic [DIST_BITS-1:0] DIST_MAX   = 18'h3FFFF;
	localparam logic [DIM_BITS-1:0]  DIMS_RESET = 4'd8;

	localparam logic [CMD_BITS-1:0] CMD_LOAD_REF  = 2'd0;
	localparam logic [CMD_BITS-1:0] CMD_LOAD_CAND = 2'd1;
	localparam logic [CMD_BITS-1:0] CMD_COMPUTE   = 2'd2;

endpackage

### rtl/cpsd_ram.sv
module cpsd_ram #(
	parameter int WIDTH = 128,
	parameter int DEPTH = 64
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/cpsd_lane.sv
module cpsd_lane #(
	parameter int COORD_BITS = 16
) (
	input  logic                          clk,
	input  logic                          en,
	input  logic signed [COORD_BITS-1:0]  a,
	input  logic signed [COORD_BITS-1:0]  b,
	output logic [2*(COORD_BITS+1)-1:0]   sq_s1
);

	localparam int DW = COORD_BITS + 1;

	logic signed [DW-1:0] diff;
	logic [DW-1:0]        mag;

	always_comb begin
		diff = DW'(a) - DW'(b);
		mag  = diff[DW-1] ? DW'(-diff) : DW'(diff);
	end

	always_ff @(posedge clk) begin
		sq_s1 <= en ? (2*DW)'(mag * mag) : '0;
	end

endmodule

### rtl/cpsd_isqrt.sv
module cpsd_isqrt #(
	parameter int XW = 37
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  logic [XW-1:0]           x,
	output logic                    done,
	output logic [(XW+1)/2-1:0]     root
);

	localparam int RW  = (XW + 1) / 2;
	localparam int PW  = 2 * RW;
	localparam int NW  = $clog2(RW + 1);

	logic [PW-1:0]   x_q;
	logic [RW+1:0]   rem_q;
	logic [RW-1:0]   root_q;
	logic [NW-1:0]   cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [RW+3:0]   rem_sh;
	logic [RW+3:0]   trial;

	always_comb begin
		rem_sh = {rem_q, x_q[PW-1:PW-2]};
		trial  = {2'b00, root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == NW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= NW'(RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - NW'(1);
				if (cnt_q == NW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// one result bit per cycle, two radicand bits consumed
	always_ff @(posedge clk) begin
		if (start) begin
			x_q    <= PW'(x);
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[PW-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= (RW+2)'(rem_sh - trial);
				root_q <= {root_q[RW-2:0], 1'b1};
			end else begin
				rem_q  <= (RW+2)'(rem_sh);
				root_q <= {root_q[RW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

### rtl/cpsd_div.sv
module cpsd_div #(
	parameter int NW = 16,
	parameter int DW = 7
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic          done,
	output logic [NW-1:0] quo
);

	localparam int CNTW = $clog2(NW + 1);

	logic [NW-1:0]   num_q;
	logic [DW-1:0]   den_q;
	logic [DW-1:0]   rem_q;
	logic [CNTW-1:0] cnt_q;
	logic            busy_q;
	logic            done_q;
	logic [DW:0]     rs;

	assign rs = {rem_q, num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && !start && (cnt_q == CNTW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNTW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNTW'(1);
				if (cnt_q == CNTW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// restoring division, quotient bits shift into the numerator register
	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			if (rs >= {1'b0, den_q}) begin
				rem_q <= DW'(rs - {1'b0, den_q});
				num_q <= {num_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= DW'(rs);
				num_q <= {num_q[NW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = num_q;

endmodule

### rtl/chamfer_point_set_distance.sv
// Chamfer distance engine. Requests on the slave stream carry a command in tuser
// (load reference point, load candidate point, compute) and eight Q8.8 coordinates
// in tdata. A load gives no result; a load into a full set is dropped and flagged
// in the next result. A compute walks every ordered pair of the two sets one pair
// at a time: a pair passes through memory read, per-coordinate squaring lanes and
// summation, then the bit-serial square root, which dominates the time per pair;
// the walk is followed by two serial divisions. The result (Q10.8 distance in
// tdata, empty flag and dropped flag in tuser) then waits in an output register
// while new loads are taken; both sets are cleared as it is issued.
module chamfer_point_set_distance #(
	parameter int MAX_POINTS = cpsd_pkg::MAX_POINTS_DEF,
	parameter int MAX_DIM    = cpsd_pkg::MAX_DIM_DEF,
	parameter int COORD_BITS = cpsd_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// coord_0 .. coord_7, coord_0 lowest
	input  logic [((cpsd_pkg::NUM_COORDS*COORD_BITS+7)/8)*8-1:0] s_tdata,
	// cmd
	input  logic [cpsd_pkg::CMD_BITS-1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// distance
	output logic [cpsd_pkg::DIST_TDATA_BITS-1:0] m_tdata,
	// empty_set, points_dropped
	output logic [1:0] m_tuser,
	input  logic cfg_we,
	input  logic [cpsd_pkg::DIM_BITS-1:0] cfg_wdata
);

	import cpsd_pkg::*;

	localparam int AW   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW   = $clog2(MAX_POINTS + 1);
	localparam int PW   = MAX_DIM * COORD_BITS;
	localparam int SQW  = 2 * (COORD_BITS + 1);
	localparam int SUMW = SQW + $clog2(MAX_DIM + 1);
	localparam int SATW = (SUMW > 64) ? 64 : SUMW;
	localparam int RW   = (SATW + 1) / 2;
	localparam int TW   = RW + CW;

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_RD   = 7'b0000010,
		S_SQ   = 7'b0000100,
		S_SUM  = 7'b0001000,
		S_ROOT = 7'b0010000,
		S_DIV  = 7'b0100000,
		S_FIN  = 7'b1000000
	} state_t;

	state_t              state_q;
	logic [DIM_BITS-1:0] dims_q;
	logic [DIM_BITS-1:0] dims_eff;
	logic [CW-1:0]       rcnt_q, ccnt_q;
	logic                ovf_q;
	logic                empty_q;
	logic                dir_q;
	logic [AW-1:0]       i_q, j_q;
	logic [RW-1:0]       best_q;
	logic [TW-1:0]       total_q, t1_q, a1_q;
	logic                div_phase_q, div_go_q;
	logic                m_tvalid_q;
	logic [DIST_BITS-1:0] dist_q;
	logic [DIST_BITS-1:0] dist_calc_q;
	logic                m_empty_q, m_drop_q;

	logic                s_acc, is_ref, is_cand, ref_we, cand_we;
	logic [AW-1:0]       ref_raddr, cand_raddr;
	logic [PW-1:0]       ref_rd, cand_rd;
	logic [SQW-1:0]      sq_s1 [MAX_DIM];
	logic [SUMW-1:0]     sum;
	logic [SATW-1:0]     sum_sat;
	logic                root_done;
	logic [RW-1:0]       root;
	logic                div_done;
	logic [TW-1:0]       quo;
	logic [CW-1:0]       nfrom, nto;
	logic                last_j, last_i;
	logic [RW-1:0]       best_n;
	logic [TW:0]         pair_sum;
	logic [TW-1:0]       half;
	logic [DIST_BITS-1:0] dist_sat;
	logic                out_free;

	assign s_tready = (state_q == S_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign is_ref   = (s_tuser == CMD_LOAD_REF);
	assign is_cand  = (s_tuser == CMD_LOAD_CAND);
	assign ref_we   = s_acc && is_ref && (rcnt_q != CW'(MAX_POINTS));
	assign cand_we  = s_acc && is_cand && (ccnt_q != CW'(MAX_POINTS));

	always_comb begin
		if (dims_q == '0) begin
			dims_eff = DIM_BITS'(1);
		end else if (dims_q > DIM_BITS'(MAX_DIM)) begin
			dims_eff = DIM_BITS'(MAX_DIM);
		end else begin
			dims_eff = dims_q;
		end
	end

	// direction 0 walks candidates against references, direction 1 the reverse
	assign ref_raddr  = dir_q ? i_q : j_q;
	assign cand_raddr = dir_q ? j_q : i_q;
	assign nfrom      = dir_q ? rcnt_q : ccnt_q;
	assign nto        = dir_q ? ccnt_q : rcnt_q;
	assign last_j     = (CW'(j_q) + CW'(1)) == nto;
	assign last_i     = (CW'(i_q) + CW'(1)) == nfrom;

	cpsd_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_ref_ram (
		.clk   (clk),
		.we    (ref_we),
		.waddr (rcnt_q[AW-1:0]),
		.wdata (s_tdata[PW-1:0]),
		.raddr (ref_raddr),
		.rdata (ref_rd)
	);

	cpsd_ram #(.WIDTH(PW), .DEPTH(MAX_POINTS)) u_cand_ram (
		.clk   (clk),
		.we    (cand_we),
		.waddr (ccnt_q[AW-1:0]),
		.wdata (s_tdata[PW-1:0]),
		.raddr (cand_raddr),
		.rdata (cand_rd)
	);

	for (genvar k = 0; k < MAX_DIM; k++) begin : g_lane
		cpsd_lane #(.COORD_BITS(COORD_BITS)) u_lane (
			.clk   (clk),
			.en    (DIM_BITS'(k) < dims_eff),
			.a     (ref_rd[k*COORD_BITS +: COORD_BITS]),
			.b     (cand_rd[k*COORD_BITS +: COORD_BITS]),
			.sq_s1 (sq_s1[k])
		);
	end

	// merge the lanes, clamp to 64 bits as the wide case needs
	always_comb begin
		sum = '0;
		for (int k = 0; k < MAX_DIM; k++) begin
			sum = sum + SUMW'(sq_s1[k]);
		end
		sum_sat = ((sum >> SATW) != '0) ? '1 : SATW'(sum);
	end

	cpsd_isqrt #(.XW(SATW)) u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (state_q == S_SUM),
		.x      (sum_sat),
		.done   (root_done),
		.root   (root)
	);

	cpsd_div #(.NW(TW), .DW(CW)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go_q),
		.num    (div_phase_q ? total_q : t1_q),
		.den    (div_phase_q ? rcnt_q : ccnt_q),
		.done   (div_done),
		.quo    (quo)
	);

	assign best_n   = ((j_q == '0) || (root < best_q)) ? root : best_q;
	assign pair_sum = {1'b0, a1_q} + {1'b0, quo};
	assign half     = pair_sum[TW:1];
	assign dist_sat = (64'(half) > 64'(DIST_MAX)) ? DIST_MAX : DIST_BITS'(half);
	assign out_free = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			dims_q      <= DIMS_RESET;
			rcnt_q      <= '0;
			ccnt_q      <= '0;
			ovf_q       <= 1'b0;
			empty_q     <= 1'b0;
			dir_q       <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			div_phase_q <= 1'b0;
			div_go_q    <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			div_go_q <= (state_q == S_ROOT && root_done && last_j && last_i && dir_q) ||
				(state_q == S_DIV && div_done && !div_phase_q);
			if (cfg_we) begin
				dims_q <= cfg_wdata;
			end
			if (state_q == S_FIN && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_acc) begin
						if (is_ref || is_cand) begin
							if (ref_we) begin
								rcnt_q <= rcnt_q + CW'(1);
							end else if (cand_we) begin
								ccnt_q <= ccnt_q + CW'(1);
							end else begin
								ovf_q <= 1'b1;
							end
						end else if (s_tuser == CMD_COMPUTE) begin
							dir_q <= 1'b0;
							i_q   <= '0;
							j_q   <= '0;
							if (rcnt_q == '0 || ccnt_q == '0) begin
								empty_q <= 1'b1;
								state_q <= S_FIN;
							end else begin
								empty_q <= 1'b0;
								state_q <= S_RD;
							end
						end
					end
				end
				S_RD:  state_q <= S_SQ;
				S_SQ:  state_q <= S_SUM;
				S_SUM: state_q <= S_ROOT;
				S_ROOT: begin
					if (root_done) begin
						if (!last_j) begin
							j_q     <= j_q + AW'(1);
							state_q <= S_RD;
						end else begin
							j_q <= '0;
							if (!last_i) begin
								i_q     <= i_q + AW'(1);
								state_q <= S_RD;
							end else begin
								i_q <= '0;
								if (!dir_q) begin
									dir_q   <= 1'b1;
									state_q <= S_RD;
								end else begin
									div_phase_q <= 1'b0;
									state_q     <= S_DIV;
								end
							end
						end
					end
				end
				S_DIV: begin
					if (div_done) begin
						if (!div_phase_q) begin
							div_phase_q <= 1'b1;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						rcnt_q  <= '0;
						ccnt_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (state_q == S_ROOT && root_done) begin
			best_q <= best_n;
			if (last_j) begin
				if (last_i && !dir_q) begin
					t1_q    <= total_q + TW'(best_n);
					total_q <= '0;
				end else begin
					total_q <= total_q + TW'(best_n);
				end
			end
		end else if (state_q == S_IDLE) begin
			total_q <= '0;
		end
		if (state_q == S_DIV && div_done && !div_phase_q) begin
			a1_q <= quo;
		end
		if (state_q == S_DIV && div_done && div_phase_q) begin
			dist_calc_q <= dist_sat;
		end
		// output fields only change as a new result is issued
		if (state_q == S_FIN && out_free) begin
			dist_q    <= empty_q ? '0 : dist_calc_q;
			m_empty_q <= empty_q;
			m_drop_q  <= ovf_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = DIST_TDATA_BITS'(dist_q);
	assign m_tuser  = {m_drop_q, m_empty_q};

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= CW'(MAX_POINTS) && ccnt_q <= CW'(MAX_POINTS))
		else $error("set count beyond capacity");

	a_root_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		root_done |-> state_q == S_ROOT)
		else $error("square root finished outside the pair walk");

	a_div_in_phase: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == S_DIV)
		else $error("division finished outside the divide phase");

	a_fin_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_free) |=> (rcnt_q == '0 && ccnt_q == '0 && m_tvalid_q))
		else $error("result issued without clearing the sets");

endmodule

### bench/tb_top.sv
module tb_top;
	import cpsd_pkg::*;

	localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
	localparam int NPTS = MAX_POINTS_DEF;

	typedef struct {
		logic [DIST_BITS-1:0] dist_val;
		bit                   empty;
		bit                   dropped;
	} chamfer_res_t;

	typedef struct {
		bit                      is_cfg;
		logic [CMD_BITS-1:0]     cmd;
		logic [127:0]            coords;
		bit                      typed;
		chamfer_res_t            res;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [127:0] s_tdata;
	logic [CMD_BITS-1:0] s_tuser;
	logic m_tvalid;
	logic m_tready;
	logic [DIST_TDATA_BITS-1:0] m_tdata;
	logic [1:0] m_tuser;
	logic cfg_we;
	logic [DIM_BITS-1:0] cfg_wdata;

	chamfer_point_set_distance uut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [127:0] ref_set [NPTS];
	logic [127:0] cand_set [NPTS];
	int unsigned ref_cnt, cand_cnt;
	bit overflow_flag;
	logic [DIM_BITS-1:0] dims_reg;

	chamfer_res_t dist_q [$];
	stim_row_t rows [$];
	int errors;
	int burst_left;
	int n_items;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 1500000);
		$display("Some tests failed");
		$finish;
	end

	function automatic longint unsigned isqrt(longint unsigned x);
		longint unsigned r;
		longint unsigned b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x)
			b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned pair_dist(logic [127:0] a, logic [127:0] b, int nd);
		longint unsigned s;
		longint df;
		s = 0;
		for (int i = 0; i < nd; i++) begin
			df = longint'($signed(a[16*i +: 16])) - longint'($signed(b[16*i +: 16]));
			if (df < 0)
				df = -df;
			s += longint'(df * df);
		end
		return isqrt(s);
	endfunction

	function automatic chamfer_res_t chamfer_of_sets();
		chamfer_res_t r;
		int nd;
		longint unsigned t1, t2, a1, a2, best, d, total;
		nd = (dims_reg < 1) ? 1 : (dims_reg > MAX_DIM_DEF) ? MAX_DIM_DEF : int'(dims_reg);
		r.dist_val = '0;
		r.empty = 1'b0;
		r.dropped = overflow_flag;
		if (ref_cnt == 0 || cand_cnt == 0) begin
			r.empty = 1'b1;
		end else begin
			t1 = 0;
			for (int i = 0; i < cand_cnt; i++) begin
				best = pair_dist(cand_set[i], ref_set[0], nd);
				for (int j = 1; j < ref_cnt; j++) begin
					d = pair_dist(cand_set[i], ref_set[j], nd);
					if (d < best)
						best = d;
				end
				t1 += best;
			end
			t2 = 0;
			for (int i = 0; i < ref_cnt; i++) begin
				best = pair_dist(ref_set[i], cand_set[0], nd);
				for (int j = 1; j < cand_cnt; j++) begin
					d = pair_dist(ref_set[i], cand_set[j], nd);
					if (d < best)
						best = d;
				end
				t2 += best;
			end
			a1 = t1 / cand_cnt;
			a2 = t2 / ref_cnt;
			total = a1 / 2 + a2 / 2 + ((a1 & 1) + (a2 & 1)) / 2;
			r.dist_val = (total > DIST_MAX) ? DIST_MAX : total[DIST_BITS-1:0];
		end
		return r;
	endfunction

	// update the predictor with an accepted request
	task automatic model_request(logic [CMD_BITS-1:0] cmd, logic [127:0] c, bit typed,
			chamfer_res_t tres);
		chamfer_res_t r;
		case (cmd)
			CMD_LOAD_REF: begin
				if (ref_cnt >= NPTS) overflow_flag = 1'b1;
				else begin
					ref_set[ref_cnt] = c;
					ref_cnt++;
				end
			end
			CMD_LOAD_CAND: begin
				if (cand_cnt >= NPTS) overflow_flag = 1'b1;
				else begin
					cand_set[cand_cnt] = c;
					cand_cnt++;
				end
			end
			CMD_COMPUTE: begin
				r = chamfer_of_sets();
				if (typed)
					r = tres;
				dist_q = {dist_q, r};
				ref_cnt = 0;
				cand_cnt = 0;
				overflow_flag = 1'b0;
			end
			default: ;
		endcase
	endtask

	task automatic send(logic [CMD_BITS-1:0] cmd, logic [127:0] c, bit typed = 0,
			chamfer_res_t tres = '{default: 0});
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if ($urandom_range(0, 3) != 0) begin
				gap = $urandom_range(1, 6);
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= c;
		do @(posedge clk); while (!s_tready);
		model_request(cmd, c, typed, tres);
		if (cmd != CMD_UNUSED)
			n_items++;
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (dist_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_dims(logic [DIM_BITS-1:0] v);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		dims_reg = v;
	endtask

	function automatic logic [127:0] rand_point(bit near);
		logic [127:0] p;
		for (int i = 0; i < 8; i++)
			p[16*i +: 16] = near ? 16'($signed($urandom_range(0, 2047)) - 1024)
				: 16'($urandom());
		return p;
	endfunction

	task automatic add_row(bit is_cfg, logic [CMD_BITS-1:0] cmd, logic [127:0] c,
			bit typed = 0, logic [DIST_BITS-1:0] d = 0, bit e = 0, bit p = 0);
		stim_row_t r;
		r.is_cfg = is_cfg;
		r.cmd = cmd;
		r.coords = c;
		r.typed = typed;
		r.res.dist_val = d;
		r.res.empty = e;
		r.res.dropped = p;
		rows = {rows, r};
	endtask

	// result side: stall pattern in stretches, check each result
	int stretch_left;
	int ready_mode;
	always @(posedge clk) begin
		chamfer_res_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (dist_q.size() == 0) begin
				$display("%0t: unexpected result dist=%0d tuser=%b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				e = dist_q.pop_front();
				if (m_tdata[DIST_BITS-1:0] !== e.dist_val) begin
					$display("%0t: distance expected %0d actual %0d", $time, e.dist_val,
						m_tdata[DIST_BITS-1:0]);
					errors++;
				end
				if (m_tuser[0] !== e.empty) begin
					$display("%0t: empty_set expected %0d actual %0d", $time, e.empty,
						m_tuser[0]);
					errors++;
				end
				if (m_tuser[1] !== e.dropped) begin
					$display("%0t: points_dropped expected %0d actual %0d", $time,
						e.dropped, m_tuser[1]);
					errors++;
				end
			end
		end
		if (stretch_left == 0) begin
			stretch_left = $urandom_range(5, 60);
			ready_mode = $urandom_range(0, 2);
		end
		stretch_left--;
		case (ready_mode)
			0: m_tready <= 1'b1;
			1: m_tready <= ($urandom_range(0, 3) != 0);
			default: m_tready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	localparam logic [127:0] ALL_MAX = {8{16'h7FFF}};
	localparam logic [127:0] ALL_MIN = {8{16'h8000}};
	localparam logic [127:0] ZEROS = '0;

	initial begin
		int nr, nc, pick;
		bit near;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = CMD_LOAD_REF;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = DIMS_RESET;
		errors = 0;
		burst_left = 0;
		n_items = 0;
		stretch_left = 0;
		ready_mode = 0;
		ref_cnt = 0;
		cand_cnt = 0;
		overflow_flag = 1'b0;
		dims_reg = DIMS_RESET;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		add_row(0, CMD_COMPUTE, ZEROS, 1, 0, 1, 0);
		add_row(0, CMD_LOAD_REF, ZEROS);
		add_row(0, CMD_COMPUTE, ZEROS, 1, 0, 1, 0);
		add_row(0, CMD_LOAD_CAND, ZEROS);
		add_row(0, CMD_COMPUTE, ZEROS, 1, 0, 1, 0);
		add_row(0, CMD_LOAD_REF, ALL_MAX);
		add_row(0, CMD_LOAD_CAND, ALL_MIN);
		add_row(0, CMD_COMPUTE, ZEROS);
		add_row(0, CMD_LOAD_REF, ZEROS);
		add_row(0, CMD_LOAD_CAND, ZEROS);
		add_row(0, CMD_COMPUTE, ZEROS, 1, 0, 0, 0);
		add_row(0, CMD_UNUSED, ALL_MAX);
		add_row(0, CMD_COMPUTE, ZEROS, 1, 0, 1, 0);
		add_row(0, CMD_LOAD_REF, 128'h0100);
		add_row(0, CMD_LOAD_CAND, ZEROS);
		add_row(0, CMD_COMPUTE, ZEROS, 1, 256, 0, 0);
		add_row(1, CMD_LOAD_REF, 128'd1);
		// coordinate above dimensions is ignored
		add_row(0, CMD_LOAD_REF, 128'h7FFF_0000);
		add_row(0, CMD_LOAD_CAND, ZEROS);
		add_row(0, CMD_COMPUTE, ZEROS, 1, 0, 0, 0);
		add_row(1, CMD_LOAD_REF, 128'd0);
		add_row(0, CMD_LOAD_REF, 128'h0200);
		add_row(0, CMD_LOAD_CAND, ZEROS);
		add_row(0, CMD_COMPUTE, ZEROS, 1, 512, 0, 0);
		add_row(1, CMD_LOAD_REF, 128'd15);
		add_row(0, CMD_LOAD_REF, ALL_MIN);
		add_row(0, CMD_LOAD_CAND, ALL_MAX);
		add_row(0, CMD_LOAD_CAND, ZEROS);
		add_row(0, CMD_COMPUTE, ZEROS);
		foreach (rows[i]) begin
			if (rows[i].is_cfg)
				set_dims(rows[i].coords[DIM_BITS-1:0]);
			else
				send(rows[i].cmd, rows[i].coords, rows[i].typed, rows[i].res);
		end
		set_dims(DIMS_RESET);

		// random phases: load two sets, usually small, then compute
		while (n_items < 1650) begin
			pick = $urandom_range(0, 29);
			if (pick == 0)
				set_dims(4'($urandom_range(0, 15)));
			if (pick == 1)
				wait_drained();
			near = $urandom_range(0, 1);
			if (pick == 2) begin
				// fill one set past full so the drop flag is raised
				nr = NPTS + $urandom_range(1, 3);
				nc = $urandom_range(1, 2);
				if ($urandom_range(0, 1)) begin
					pick = nr;
					nr = nc;
					nc = pick;
				end
			end else begin
				nr = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
				nc = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
			end
			while (nr > 0 || nc > 0) begin
				if ($urandom_range(0, 19) == 0)
					send(CMD_UNUSED, rand_point(0));
				if (nc == 0 || (nr > 0 && $urandom_range(0, 1))) begin
					send(CMD_LOAD_REF, rand_point(near));
					nr--;
				end else begin
					send(CMD_LOAD_CAND, rand_point(near));
					nc--;
				end
			end
			send(CMD_COMPUTE, rand_point(0));
		end

		wait_drained();
		repeat (30) @(posedge clk);
		if (errors == 0 && dist_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
